FILE: sv/wlh_pkg.sv
// shared constants for the word length histogram
package wlh_pkg;

    localparam int CHAR_W = 8;
    localparam int CNT_W  = 16;
    localparam int IDX_W  = 4;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef logic [CNT_W-1:0] t_count;

endpackage

FILE: sv/wlh_ifs.sv
// character input and bin readout channel interfaces
interface wlh_in_if;
    logic                       valid;
    logic                       ready;
    logic [wlh_pkg::CHAR_W-1:0] char_code;
    logic                       end_of_input;

    modport source (output valid, char_code, end_of_input, input ready);
    modport sink (input valid, char_code, end_of_input, output ready);
endinterface

interface wlh_out_if;
    logic                      valid;
    logic                      ready;
    logic [wlh_pkg::IDX_W-1:0] bin_index;
    wlh_pkg::t_count           bin_count;
    wlh_pkg::t_count           longest_word;
    wlh_pkg::t_count           largest_bin;
    logic                      last_bin;

    modport source (output valid, bin_index, bin_count, longest_word, largest_bin, last_bin,
                    input ready);
    modport sink (input valid, bin_index, bin_count, longest_word, largest_bin, last_bin,
                  output ready);
endinterface

FILE: sv/wlh_bin_mem.sv
// bin count memory with registered read and per-entry valid bits
module wlh_bin_mem #(
    parameter int DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_clr_en,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wlh_pkg::t_count          i_wr_data,
    output wlh_pkg::t_count          o_rd_data
);

    wlh_pkg::t_count   mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    wlh_pkg::t_count   r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // entries never written since reset or the last readout read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
            if (i_clr_en) begin
                r_valid[i_rd_addr] <= 1'b0;
            end
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: sv/word_length_histogram_top.sv
// word length histogram: top level with word tracking and readout sequencer
//
// Input channel i_in carries one character per transaction plus an
// end_of_input flag. Space, tab and newline end a word; end_of_input ends the
// current word too and starts the readout. Characters are taken one per
// cycle outside the readout; a finished word reads its bin from the count
// memory and r_upd_vld then writes the incremented count back.
// Output channel o_out delivers MAX_WORD_LEN+1 transactions after each
// end_of_input, bins 0 to MAX_WORD_LEN in order, the last flagged by
// last_bin, each carrying the longest word length and the largest count.
// The first result follows the S_DRAIN state, which lets the pending bin
// write land, and the memory read of bin 0; results then come one per
// cycle while o_out.ready is high. i_in.ready stays low from the
// end_of_input transaction until the last result is taken.
// A stalled receiver holds the output register; the next memory read is
// issued only when the current result leaves.
// Each bin is cleared as it is read; the word length returns to zero at end_of_input,
// the maxima after the last result. Reset clears the control state and memory valid bits.
module word_length_histogram_top #(
    parameter int MAX_WORD_LEN = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wlh_in_if.sink     i_in,
    wlh_out_if.source  o_out
);

    localparam int NUM_BINS = MAX_WORD_LEN + 1;
    localparam int AW       = $clog2(NUM_BINS);
    localparam logic [wlh_pkg::CNT_W-1:0] MAX_LEN = wlh_pkg::CNT_W'(MAX_WORD_LEN);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_WORD_LEN);

    typedef enum logic [1:0] {
        S_RUN,
        S_DRAIN,
        S_READ
    } t_state;

    t_state            r_state;
    wlh_pkg::t_count   r_len;
    wlh_pkg::t_count   r_longest;
    wlh_pkg::t_count   r_largest;
    logic              r_upd_vld;
    logic [AW-1:0]     r_upd_addr;
    logic [AW-1:0]     r_idx;
    logic              r_issue_done;
    logic              r_out_valid;
    logic [AW-1:0]     r_out_idx;
    logic              r_out_last;

    logic              in_acc;
    logic              is_sep;
    logic              word_end;
    logic [AW-1:0]     word_addr;
    logic              rd_go;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    wlh_pkg::t_count   mem_rd_data;
    wlh_pkg::t_count   n_count;
    logic              out_acc;

    assign i_in.ready = (r_state == S_RUN);
    assign in_acc     = i_in.valid && i_in.ready;
    assign is_sep     = i_in.end_of_input || (i_in.char_code == wlh_pkg::CH_SPACE) ||
                        (i_in.char_code == wlh_pkg::CH_TAB) ||
                        (i_in.char_code == wlh_pkg::CH_NEWLINE);
    assign word_end   = in_acc && is_sep && (r_len != '0);
    assign word_addr  = (r_len <= MAX_LEN) ? AW'(r_len - 1'b1) : LAST_IDX;

    assign out_acc    = r_out_valid && o_out.ready;
    assign rd_go      = (r_state == S_READ) && !r_issue_done && (!r_out_valid || o_out.ready);

    assign mem_rd_en   = word_end || rd_go;
    assign mem_rd_addr = rd_go ? r_idx : word_addr;

    // saturating increment of the bin read on the previous cycle
    assign n_count = (mem_rd_data == wlh_pkg::CNT_MAX) ? mem_rd_data : mem_rd_data + 1'b1;

    wlh_bin_mem #(
        .DEPTH (NUM_BINS)
    ) u_bin_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .i_clr_en  (rd_go),
        .i_wr_en   (r_upd_vld),
        .i_wr_addr (r_upd_addr),
        .i_wr_data (n_count),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_len        <= '0;
            r_longest    <= '0;
            r_largest    <= '0;
            r_upd_vld    <= 1'b0;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_upd_vld <= word_end;
            if (word_end) begin
                r_upd_addr <= word_addr;
                if (r_len > r_longest) begin
                    r_longest <= r_len;
                end
            end
            if (r_upd_vld && (n_count > r_largest)) begin
                r_largest <= n_count;
            end

            unique case (r_state)
                S_RUN: begin
                    if (in_acc) begin
                        if (is_sep) begin
                            r_len <= '0;
                        end else if (r_len != wlh_pkg::CNT_MAX) begin
                            r_len <= r_len + 1'b1;
                        end
                        if (i_in.end_of_input) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                // lets the final bin write land before the readout reads
                S_DRAIN: begin
                    r_idx        <= '0;
                    r_issue_done <= 1'b0;
                    r_state      <= S_READ;
                end
                S_READ: begin
                    if (rd_go) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= r_idx;
                        r_out_last  <= (r_idx == LAST_IDX);
                        if (r_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else if (out_acc) begin
                        r_out_valid <= 1'b0;
                    end
                    if (out_acc && r_out_last) begin
                        r_out_last  <= 1'b0;
                        r_longest   <= '0;
                        r_largest   <= '0;
                        r_state     <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.bin_index    = wlh_pkg::IDX_W'(r_out_idx);
    assign o_out.bin_count    = mem_rd_data;
    assign o_out.longest_word = r_longest;
    assign o_out.largest_bin  = r_largest;
    assign o_out.last_bin     = r_out_last;

    a_no_update_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_upd_vld)
        else $error("bin update pending during readout");

    a_out_only_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_READ))
        else $error("result valid outside readout");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_out_last) |=> (r_longest == '0 && r_largest == '0 && r_state == S_RUN))
        else $error("maxima not cleared after last transaction");

    a_len_zero_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_DRAIN) |-> (r_len == '0))
        else $error("word length not cleared at end of input");

    a_read_not_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_go && r_idx == LAST_IDX) |=> !rd_go)
        else $error("read issued past last bin");

endmodule

FILE: test/wlh_checker.sv
// checker: predicts bin readouts from accepted characters and compares each result
`timescale 1ns / 1ps
module wlh_checker #(
    parameter int MAX_WORD_LEN = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    wlh_in_if    i_in_mon,
    wlh_out_if   i_out_mon,
    output int   o_errors,
    output int   o_pending,
    output int   o_results
);

    localparam int NUM_BINS = MAX_WORD_LEN + 1;

    typedef struct packed {
        logic [wlh_pkg::IDX_W-1:0] bin_index;
        wlh_pkg::t_count           bin_count;
        wlh_pkg::t_count           longest_word;
        wlh_pkg::t_count           largest_bin;
        logic                      last_bin;
    } t_bin_result;

    wlh_pkg::t_count word_len    = '0;
    wlh_pkg::t_count bin_tally [NUM_BINS] = '{default: '0};
    wlh_pkg::t_count longest_len = '0;
    wlh_pkg::t_count peak_tally  = '0;
    t_bin_result     bins_due [$];
    int              error_count  = 0;
    int              result_count = 0;

    // a separator or end of stream closes the word in progress
    function automatic void close_word();
        int bin;
        if (word_len != '0) begin
            bin = (word_len <= MAX_WORD_LEN) ? int'(word_len) - 1 : MAX_WORD_LEN;
            if (bin_tally[bin] != wlh_pkg::CNT_MAX) begin
                bin_tally[bin] = bin_tally[bin] + 1'b1;
            end
            if (bin_tally[bin] > peak_tally) begin
                peak_tally = bin_tally[bin];
            end
            if (word_len > longest_len) begin
                longest_len = word_len;
            end
        end
        word_len = '0;
    endfunction

    function automatic void take_char(input logic [wlh_pkg::CHAR_W-1:0] ch, input logic eoi);
        t_bin_result r;
        int          k;
        if (!eoi) begin
            if (ch == wlh_pkg::CH_SPACE || ch == wlh_pkg::CH_TAB ||
                ch == wlh_pkg::CH_NEWLINE) begin
                close_word();
            end else if (word_len != wlh_pkg::CNT_MAX) begin
                word_len = word_len + 1'b1;
            end
        end else begin
            close_word();
            for (k = 0; k < NUM_BINS; k++) begin
                r.bin_index    = wlh_pkg::IDX_W'(k);
                r.bin_count    = bin_tally[k];
                r.longest_word = longest_len;
                r.largest_bin  = peak_tally;
                r.last_bin     = (k == NUM_BINS - 1);
                bins_due.push_back(r);
                bin_tally[k] = '0;
            end
            longest_len = '0;
            peak_tally  = '0;
        end
    endfunction

    function automatic int field_diff(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_bin_result want;
        if (!i_rst_n) begin
            word_len    = '0;
            longest_len = '0;
            peak_tally  = '0;
            bin_tally   = '{default: '0};
            bins_due.delete();
        end else begin
            // results come from earlier transactions, so check them first
            if (i_out_mon.valid && i_out_mon.ready) begin
                result_count++;
                if (bins_due.size() == 0) begin
                    $display("%0t: unexpected bin result, expected none, got bin %0d count %0d",
                             $time, i_out_mon.bin_index, i_out_mon.bin_count);
                    error_count++;
                end else begin
                    want = bins_due.pop_front();
                    error_count += field_diff("bin_index", want.bin_index,
                                              i_out_mon.bin_index);
                    error_count += field_diff("bin_count", want.bin_count,
                                              i_out_mon.bin_count);
                    error_count += field_diff("longest_word", want.longest_word,
                                              i_out_mon.longest_word);
                    error_count += field_diff("largest_bin", want.largest_bin,
                                              i_out_mon.largest_bin);
                    error_count += field_diff("last_bin", want.last_bin,
                                              i_out_mon.last_bin);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                take_char(i_in_mon.char_code, i_in_mon.end_of_input);
            end
        end
        o_errors  <= error_count;
        o_pending <= bins_due.size();
        o_results <= result_count;
    end

endmodule

FILE: test/word_length_histogram_top_tb.sv
// testbench top: clock, reset, character streams and the final verdict
`timescale 1ns / 1ps
module word_length_histogram_top_tb;

    localparam int MAX_LEN      = 10;
    localparam int RANDOM_ITEMS = 420;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    int   chars_sent   = 0;
    int   streams_sent = 0;
    int   checker_errors;
    int   bins_pending;
    int   bins_checked;

    wlh_in_if  in_ch ();
    wlh_out_if out_ch ();

    word_length_histogram_top #(.MAX_WORD_LEN(MAX_LEN)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wlh_checker #(.MAX_WORD_LEN(MAX_LEN)) i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_mon  (in_ch),
        .i_out_mon (out_ch),
        .o_errors  (checker_errors),
        .o_pending (bins_pending),
        .o_results (bins_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : receiver
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : watchdog
        #(64'd2_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_char(input logic [wlh_pkg::CHAR_W-1:0] ch, input logic eoi);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.char_code    <= ch;
        in_ch.end_of_input <= eoi;
        do @(posedge i_clk); while (!in_ch.ready);
        chars_sent++;
        if (eoi) begin
            streams_sent++;
        end
    endtask

    function automatic logic [wlh_pkg::CHAR_W-1:0] word_char();
        logic [wlh_pkg::CHAR_W-1:0] c;
        do c = wlh_pkg::CHAR_W'($urandom_range(255));
        while (c == wlh_pkg::CH_SPACE || c == wlh_pkg::CH_TAB || c == wlh_pkg::CH_NEWLINE);
        return c;
    endfunction

    task automatic send_word(input int len);
        repeat (len) send_char(word_char(), 1'b0);
    endtask

    task automatic send_gap(input int n);
        logic [wlh_pkg::CHAR_W-1:0] sep;
        repeat (n) begin
            case ($urandom_range(2))
                0: sep = wlh_pkg::CH_SPACE;
                1: sep = wlh_pkg::CH_TAB;
                default: sep = wlh_pkg::CH_NEWLINE;
            endcase
            send_char(sep, 1'b0);
        end
    endtask

    // sender stays quiet until the whole readout has been taken
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (bins_pending != 0);
    endtask

    // mostly well-formed text ending in end of input, some raw byte noise
    task automatic random_stream();
        int n_words;
        int len;
        int i;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) send_char(wlh_pkg::CHAR_W'($urandom()), 1'b0);
        end else begin
            if ($urandom_range(3) == 0) begin
                send_gap($urandom_range(1, 3));
            end
            n_words = $urandom_range(1, 6);
            for (i = 0; i < n_words; i++) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
                send_word(len);
                if (i < n_words - 1 || $urandom_range(1) == 1) begin
                    send_gap($urandom_range(1, 3));
                end
            end
        end
        send_char(wlh_pkg::CHAR_W'($urandom()), 1'b1);
    endtask

    initial begin : stimulus
        int phase;
        int random_base;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.char_code    <= '0;
        in_ch.end_of_input <= 1'b0;
        tx_idle_pct = 14;
        rx_idle_pct <= 48;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stream reads out all zero bins
        send_char(wlh_pkg::CH_SPACE, 1'b1);
        // one-char word, separator run, two-char word, then overflow word closed by eoi
        send_char(8'hFF, 1'b0);
        send_char(wlh_pkg::CH_TAB, 1'b0);
        send_char(wlh_pkg::CH_NEWLINE, 1'b0);
        send_char(wlh_pkg::CH_SPACE, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(wlh_pkg::CH_SPACE, 1'b0);
        send_word(MAX_LEN + 1);
        send_char(8'hA5, 1'b1);
        hold_until_drained();

        random_base = chars_sent;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 14;
                    rx_idle_pct <= 48;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_idle_pct <= 14;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            while (chars_sent - random_base < (phase + 1) * RANDOM_ITEMS / 3) begin
                random_stream();
            end
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d characters in %0d streams, %0d bin results compared",
                 chars_sent, streams_sent, bins_checked);
        $display("included empty stream, overflow words, separator runs and stalled readouts");
        if (checker_errors == 0 && bins_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
